@@ hw/rtl/cle_pkg.sv @@
`default_nettype none

package cle_pkg;

   localparam int LINE_DEPTH = 128;
   localparam int RING_DEPTH = 128;
   localparam int LINE_AW    = $clog2(LINE_DEPTH);
   localparam int RING_AW    = $clog2(RING_DEPTH);

   localparam logic [7:0] CH_ETX   = 8'h03;
   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_FF    = 8'h0C;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_ESC   = 8'h1B;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TILDE = 8'h7E;
   localparam logic [7:0] CH_DEL   = 8'h7F;

   typedef enum logic [2:0] {
      KIND_ECHO  = 3'd0,
      KIND_CLEAR = 3'd1,
      KIND_ABORT = 3'd2,
      KIND_DATA  = 3'd3,
      KIND_EMPTY = 3'd4
   } kind_type;

   typedef enum logic [3:0] {
      ACT_NONE,
      ACT_ESC_START,
      ACT_ESC_END,
      ACT_CLEAR,
      ACT_ABORT,
      ACT_STORE,
      ACT_ERASE,
      ACT_COMMIT,
      ACT_READ,
      ACT_EMPTY
   } action_type;

   typedef enum logic [1:0] {
      SEL_CONST,
      SEL_CHAR,
      SEL_RING
   } sel_type;

   typedef struct packed {
      logic       take;
      logic       set_esc;
      logic       clr_esc;
      logic       set_halt;
      logic       store_char;
      logic       erase;
      logic       read_pop;
      logic       commit_start;
      logic       commit_step;
      logic       commit_nl;
      logic       emit;
      kind_type   emit_kind;
      sel_type    emit_sel;
      logic [7:0] emit_data;
      logic       emit_last;
   } cmd_type;

   typedef struct packed {
      logic       accepted;
      action_type action;
      logic       slot_free;
      logic       commit_done;
   } status_type;

   function automatic action_type cle_classify(
      input logic       op,
      input logic [7:0] b,
      input logic       halted,
      input logic       esc,
      input logic       line_empty,
      input logic       line_full,
      input logic       ring_empty
   );
      action_type act;
      act = ACT_NONE;
      if (halted) begin
         act = ACT_NONE;
      end else if (op) begin
         act = ring_empty ? ACT_EMPTY : ACT_READ;
      end else if (esc) begin
         if (b inside {[8'h41:8'h5A], [8'h61:8'h7A], CH_TILDE}) begin
            act = ACT_ESC_END;
         end
      end else begin
         case (b)
            CH_ESC: act = ACT_ESC_START;
            CH_FF:  act = ACT_CLEAR;
            CH_ETX: act = ACT_ABORT;
            CH_CR, CH_LF: act = ACT_COMMIT;
            CH_DEL, CH_BS: act = line_empty ? ACT_NONE : ACT_ERASE;
            default: begin
               if (b inside {CH_TAB, [CH_SPACE:CH_TILDE]}) begin
                  act = line_full ? ACT_NONE : ACT_STORE;
               end
            end
         endcase
      end
      return act;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/cle_if.sv @@
`default_nettype none

interface cle_req_if import cle_pkg::*; ();
   logic       valid;
   logic       ready;
   logic       operation;
   logic [7:0] rx_byte;

   modport source (output valid, output operation, output rx_byte, input ready);
   modport sink   (input valid, input operation, input rx_byte, output ready);
endinterface

interface cle_rsp_if import cle_pkg::*; ();
   logic       valid;
   logic       ready;
   kind_type   kind;
   logic [7:0] data;
   logic       last;

   modport source (output valid, output kind, output data, output last, input ready);
   modport sink   (input valid, input kind, input data, input last, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/cle_ram.sv @@
`default_nettype none

module cle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

@@ hw/rtl/cle_datapath.sv @@
`default_nettype none

module cle_datapath import cle_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   cle_req_if.sink      req_chan,
   cle_rsp_if.source    rsp_chan,
   input  wire cmd_type cmd,
   output status_type   status
);

   logic               item_op_ff;
   logic [7:0]         item_byte_ff;
   logic [LINE_AW-1:0] line_cnt_ff, line_cnt_in;
   logic [LINE_AW-1:0] idx_ff, idx_in;
   logic               pend_ff, pend_in;
   logic               esc_ff, esc_in;
   logic               halted_ff, halted_in;
   logic [RING_AW-1:0] wp_ff, wp_in;
   logic [RING_AW-1:0] rp_ff, rp_in;
   logic               rsp_valid_ff, rsp_valid_in;
   kind_type           rsp_kind_ff;
   logic [7:0]         rsp_data_ff;
   logic               rsp_last_ff;

   logic               accept;
   logic [7:0]         store_ch;
   logic [7:0]         line_rd;
   logic [7:0]         ring_rd;
   logic               ring_we;
   logic [7:0]         ring_wdata;
   logic [RING_AW-1:0] wp_next;
   logic [RING_AW-1:0] rp_next;
   logic               ring_full;
   logic               line_full;
   logic               slot_free;
   logic [7:0]         emit_data;

   assign req_chan.ready = cmd.take;
   assign accept         = req_chan.valid && cmd.take;

   assign store_ch  = (item_byte_ff == CH_TAB) ? CH_SPACE : item_byte_ff;
   assign wp_next   = (wp_ff == RING_AW'(RING_DEPTH - 1)) ? '0 : wp_ff + RING_AW'(1);
   assign rp_next   = (rp_ff == RING_AW'(RING_DEPTH - 1)) ? '0 : rp_ff + RING_AW'(1);
   assign ring_full = (wp_next == rp_ff);
   assign line_full = (line_cnt_ff == LINE_AW'(LINE_DEPTH - 1));
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;

   // drop committed characters silently once the ring is full
   assign ring_we    = ((cmd.commit_step && pend_ff) || cmd.commit_nl) && !ring_full;
   assign ring_wdata = cmd.commit_nl ? CH_LF : line_rd;

   cle_ram #(.WIDTH(8), .DEPTH(LINE_DEPTH)) u_line_ram (
      .clock (clock),
      .we    (cmd.store_char),
      .waddr (line_cnt_ff),
      .wdata (store_ch),
      .raddr (idx_ff),
      .rdata (line_rd)
   );

   cle_ram #(.WIDTH(8), .DEPTH(RING_DEPTH)) u_ring_ram (
      .clock (clock),
      .we    (ring_we),
      .waddr (wp_ff),
      .wdata (ring_wdata),
      .raddr (rp_ff),
      .rdata (ring_rd)
   );

   always_comb begin
      status.accepted    = accept;
      status.action      = cle_classify(item_op_ff, item_byte_ff, halted_ff, esc_ff,
                                        line_cnt_ff == '0, line_full, rp_ff == wp_ff);
      status.slot_free   = slot_free;
      status.commit_done = (idx_ff == line_cnt_ff) && !pend_ff;
   end

   always_comb begin
      case (cmd.emit_sel)
         SEL_CHAR: emit_data = store_ch;
         SEL_RING: emit_data = ring_rd;
         default:  emit_data = cmd.emit_data;
      endcase
   end

   always_comb begin
      line_cnt_in = line_cnt_ff;
      if (cmd.store_char) begin
         line_cnt_in = line_cnt_ff + LINE_AW'(1);
      end else if (cmd.erase) begin
         line_cnt_in = line_cnt_ff - LINE_AW'(1);
      end else if (cmd.commit_nl) begin
         line_cnt_in = '0;
      end

      idx_in  = idx_ff;
      pend_in = pend_ff;
      if (cmd.commit_start) begin
         idx_in  = '0;
         pend_in = 1'b0;
      end else if (cmd.commit_step) begin
         if (idx_ff != line_cnt_ff) begin
            idx_in  = idx_ff + LINE_AW'(1);
            pend_in = 1'b1;
         end else begin
            pend_in = 1'b0;
         end
      end

      esc_in    = (esc_ff || cmd.set_esc) && !cmd.clr_esc;
      halted_in = halted_ff || cmd.set_halt;
      wp_in     = ring_we ? wp_next : wp_ff;
      rp_in     = cmd.read_pop ? rp_next : rp_ff;

      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_cnt_ff  <= '0;
         idx_ff       <= '0;
         pend_ff      <= 1'b0;
         esc_ff       <= 1'b0;
         halted_ff    <= 1'b0;
         wp_ff        <= '0;
         rp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         line_cnt_ff  <= line_cnt_in;
         idx_ff       <= idx_in;
         pend_ff      <= pend_in;
         esc_ff       <= esc_in;
         halted_ff    <= halted_in;
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_op_ff   <= req_chan.operation;
         item_byte_ff <= req_chan.rx_byte;
      end
      if (cmd.emit) begin
         rsp_kind_ff <= cmd.emit_kind;
         rsp_data_ff <= emit_data;
         rsp_last_ff <= cmd.emit_last;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.kind  = rsp_kind_ff;
   assign rsp_chan.data  = rsp_data_ff;
   assign rsp_chan.last  = rsp_last_ff;

   a_emit_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> slot_free)
      else $error("result beat loaded over a pending beat");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.read_pop |-> rp_ff != wp_ff)
      else $error("ring popped while empty");

   a_store_room: assert property (@(posedge clock) disable iff (reset)
      cmd.store_char |-> !line_full && !halted_ff)
      else $error("character stored into a full line or while halted");

   a_erase_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.erase |-> line_cnt_ff != '0)
      else $error("erase on an empty line");

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff && !cmd.emit)
      else $error("halt released or result emitted while halted");

endmodule

`default_nettype wire

@@ hw/rtl/cle_ctrl.sv @@
`default_nettype none

module cle_ctrl import cle_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire status_type status,
   output cmd_type         cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_ERASE_SP,
      S_ERASE_BS,
      S_COMMIT,
      S_COMMIT_NL
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd       = '0;
      cmd.emit_kind = KIND_ECHO;
      cmd.emit_sel  = SEL_CONST;
      state_in  = state_ff;

      case (state_ff)
         S_IDLE: begin
            cmd.take = 1'b1;
            if (status.accepted) begin
               state_in = S_DECODE;
            end
         end

         S_DECODE: begin
            case (status.action)
               ACT_ESC_START: begin
                  cmd.set_esc = 1'b1;
                  state_in    = S_IDLE;
               end
               ACT_ESC_END: begin
                  cmd.clr_esc = 1'b1;
                  state_in    = S_IDLE;
               end
               ACT_CLEAR: begin
                  if (status.slot_free) begin
                     cmd.emit      = 1'b1;
                     cmd.emit_kind = KIND_CLEAR;
                     cmd.emit_last = 1'b1;
                     state_in      = S_IDLE;
                  end
               end
               ACT_ABORT: begin
                  if (status.slot_free) begin
                     cmd.emit      = 1'b1;
                     cmd.emit_kind = KIND_ABORT;
                     cmd.emit_last = 1'b1;
                     cmd.set_halt  = 1'b1;
                     state_in      = S_IDLE;
                  end
               end
               ACT_STORE: begin
                  if (status.slot_free) begin
                     cmd.store_char = 1'b1;
                     cmd.emit       = 1'b1;
                     cmd.emit_sel   = SEL_CHAR;
                     cmd.emit_last  = 1'b1;
                     state_in       = S_IDLE;
                  end
               end
               ACT_ERASE: begin
                  if (status.slot_free) begin
                     cmd.emit      = 1'b1;
                     cmd.emit_data = CH_BS;
                     state_in      = S_ERASE_SP;
                  end
               end
               ACT_COMMIT: begin
                  if (status.slot_free) begin
                     cmd.emit         = 1'b1;
                     cmd.emit_data    = CH_LF;
                     cmd.emit_last    = 1'b1;
                     cmd.commit_start = 1'b1;
                     state_in         = S_COMMIT;
                  end
               end
               ACT_READ: begin
                  if (status.slot_free) begin
                     cmd.emit      = 1'b1;
                     cmd.emit_kind = KIND_DATA;
                     cmd.emit_sel  = SEL_RING;
                     cmd.emit_last = 1'b1;
                     cmd.read_pop  = 1'b1;
                     state_in      = S_IDLE;
                  end
               end
               ACT_EMPTY: begin
                  if (status.slot_free) begin
                     cmd.emit      = 1'b1;
                     cmd.emit_kind = KIND_EMPTY;
                     cmd.emit_last = 1'b1;
                     state_in      = S_IDLE;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end

         S_ERASE_SP: begin
            if (status.slot_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_data = CH_SPACE;
               state_in      = S_ERASE_BS;
            end
         end

         S_ERASE_BS: begin
            if (status.slot_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_data = CH_BS;
               cmd.emit_last = 1'b1;
               cmd.erase     = 1'b1;
               state_in      = S_IDLE;
            end
         end

         S_COMMIT: begin
            // read one line character per cycle, push it into the ring in the cycle after
            if (status.commit_done) begin
               state_in = S_COMMIT_NL;
            end else begin
               cmd.commit_step = 1'b1;
            end
         end

         S_COMMIT_NL: begin
            cmd.commit_nl = 1'b1;
            state_in      = S_IDLE;
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_take_idle_only: assert property (@(posedge clock) disable iff (reset)
      status.accepted |=> state_ff == S_DECODE)
      else $error("accepted beat not decoded next cycle");

   a_commit_ends_nl: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_COMMIT && status.commit_done) |=> state_ff == S_COMMIT_NL)
      else $error("line commit did not close with a newline push");

   a_erase_sequence: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ERASE_SP && cmd.emit) |=> state_ff == S_ERASE_BS)
      else $error("erase echo sequence broken");

endmodule

`default_nettype wire

@@ hw/rtl/console_line_editor_core.sv @@
`default_nettype none
// Channel    Dir  Payload                           Beat
// req_chan   in   operation[0], rx_byte[7:0]        valid && ready
// rsp_chan   out  kind[2:0], data[7:0], last[0]     valid && ready
//
// One item at a time: accept cycle, then decode; most items finish in decode.
// An erase echoes BS, space, BS from decode and two erase states; a line commit
// feeds the ring from the single read port of the line memory one char a cycle.
// A result waits in the output register; the next item is taken while it waits.
// Synchronous active-high reset clears control state; memories are not cleared.

module console_line_editor_core import cle_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   cle_req_if.sink   req_chan,
   cle_rsp_if.source rsp_chan
);

   cmd_type    cmd;
   status_type status;

   cle_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   cle_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .cmd      (cmd),
      .status   (status)
   );

endmodule

`default_nettype wire
